// ----- design/edf_pkg.sv -----
// Shared types, constants and the execution-time table of the EDF scheduler.
package edf_pkg;

  localparam int TIME_W   = 64;
  localparam int FACTOR_W = 8;
  localparam int EXEC_W   = 18;
  localparam int PERIOD_W = EXEC_W + FACTOR_W;
  localparam int TID_W    = 4;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd20;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [TIME_W-1:0] now;
  } item_t;

  // Command from the sequencer to the ready queue.
  typedef struct packed {
    logic              clr;
    logic              ins;
    logic              pop;
    logic [TID_W-1:0]  tid;
    logic [TIME_W-1:0] dl;
  } qcmd_t;

  typedef struct packed {
    logic             vld;
    logic [TID_W-1:0] tid;
  } qhead_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // Execution-time word of each task; tasks not listed use the short word.
  function automatic logic [EXEC_W-1:0] exec_word(input logic [TID_W-1:0] idx);
    logic [EXEC_W-1:0] w;
    unique case (idx)
      4'd0:    w = 18'd15;
      4'd5:    w = 18'd220000;
      4'd6:    w = 18'd5000;
      4'd7:    w = 18'd40000;
      4'd8:    w = 18'd60000;
      default: w = 18'd5;
    endcase
    return w;
  endfunction

endpackage

// ----- design/edf_ifs.sv -----
// Valid/ready channel interfaces of the EDF scheduler.
interface edf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [edf_pkg::TIME_W-1:0] now_us;
  modport source (output valid, req_type, now_us, input ready);
  modport sink   (input valid, req_type, now_us, output ready);
endinterface

interface edf_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      dispatched;
  logic [edf_pkg::TID_W-1:0] task_index;
  modport source (output valid, dispatched, task_index, input ready);
  modport sink   (input valid, dispatched, task_index, output ready);
endinterface

interface edf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [edf_pkg::FACTOR_W-1:0] period_factor;
  modport source (output valid, period_factor, input ready);
  modport sink   (input valid, period_factor, output ready);
endinterface

// ----- design/edf_front.sv -----
// Front end: accepts request beats, classifies them and holds them in a two-entry queue.
module edf_front (
  input  logic            clk,
  input  logic            rst_n,
  edf_req_if.sink         in_req,
  output logic            item_vld,
  output edf_pkg::item_t  item,
  input  logic            item_take
);

  edf_pkg::item_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push;
  edf_pkg::kind_t kind;

  always_comb begin
    unique case (in_req.req_type)
      1'b0:    kind = edf_pkg::KIND_START;
      1'b1:    kind = edf_pkg::KIND_TICK;
      default: kind = edf_pkg::KIND_TICK;
    endcase
  end

  assign in_req.ready = (cnt_r != 2'd2);
  assign push         = in_req.valid && in_req.ready;
  assign item_vld     = (cnt_r != 2'd0);
  assign item         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (item_take) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, item_take})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{kind: kind, now: in_req.now_us};
    end
  end

endmodule

// ----- design/edf_rdyq.sv -----
// Ready queue kept sorted by absolute deadline, one compare cell per slot.
module edf_rdyq #(
  parameter int NUM_TASKS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  edf_pkg::qcmd_t   cmd,
  output edf_pkg::qhead_t  head
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic [NUM_TASKS-1:0]       vld_r;
  logic [IDX_W-1:0]           tid_r [NUM_TASKS];
  logic [edf_pkg::TIME_W-1:0] dl_r  [NUM_TASKS];
  logic [NUM_TASKS-1:0]       lt;
  logic [NUM_TASKS-1:0]       lt_prev;

  // A slot goes behind the new entry when it is empty or strictly later.
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      lt[i] = !vld_r[i] || (cmd.dl < dl_r[i]);
    end
  end

  assign lt_prev = lt << 1;

  assign head.vld = vld_r[0];
  assign head.tid = edf_pkg::TID_W'(tid_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clr) begin
      vld_r <= '0;
    end else if (cmd.ins) begin
      vld_r <= vld_r | (lt & ~lt_prev) | (vld_r << 1);
    end else if (cmd.pop) begin
      vld_r <= vld_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (lt[0]) begin
        tid_r[0] <= cmd.tid[IDX_W-1:0];
        dl_r[0]  <= cmd.dl;
      end
      for (int i = 1; i < NUM_TASKS; i++) begin
        if (lt_prev[i]) begin
          tid_r[i] <= tid_r[i-1];
          dl_r[i]  <= dl_r[i-1];
        end else if (lt[i]) begin
          tid_r[i] <= cmd.tid[IDX_W-1:0];
          dl_r[i]  <= cmd.dl;
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < NUM_TASKS - 1; i++) begin
        tid_r[i] <= tid_r[i+1];
        dl_r[i]  <= dl_r[i+1];
      end
    end
  end

  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_r >> 1) & ~vld_r) == '0)
    else $error("ready queue has a hole");

  a_ins_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.ins && cmd.pop))
    else $error("insert and pop in the same cycle");

endmodule

// ----- design/edf_back.sv -----
// Back end: per-task release sequencer, task tables and the result register.
module edf_back #(
  parameter int NUM_TASKS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_vld,
  input  edf_pkg::item_t               item,
  output logic                         item_take,
  input  logic [edf_pkg::FACTOR_W-1:0] factor,
  output edf_pkg::qcmd_t               q_cmd,
  input  edf_pkg::qhead_t              q_head,
  edf_rsp_if.source                    out_rsp
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  edf_pkg::state_t state_r, state_nxt;
  edf_pkg::kind_t  kind_r;
  logic [edf_pkg::TIME_W-1:0]   now_r;
  logic [IDX_W-1:0]             idx_r;
  logic [edf_pkg::PERIOD_W-1:0] period_r [NUM_TASKS];
  logic [edf_pkg::TIME_W-1:0]   nrel_r   [NUM_TASKS];
  logic [NUM_TASKS-1:0]         busy_r;

  logic                         p_vld_r;
  logic [IDX_W-1:0]             p_idx_r;
  logic                         p_ins_r;
  logic [edf_pkg::TIME_W-1:0]   p_val_r;

  logic                         out_vld_r;
  logic                         out_disp_r;
  logic [edf_pkg::TID_W-1:0]    out_tid_r;

  logic                         scan;
  logic                         res_wr;
  logic                         do_pop;
  logic                         rel;
  logic [edf_pkg::TIME_W-1:0]   cur_nrel;
  logic [edf_pkg::TIME_W-1:0]   sum;
  logic [edf_pkg::EXEC_W-1:0]   ex;
  logic [edf_pkg::PERIOD_W-1:0] prod;

  assign cur_nrel = nrel_r[idx_r];
  assign rel      = (cur_nrel <= now_r);
  assign sum      = cur_nrel + edf_pkg::TIME_W'(period_r[idx_r]);
  assign ex       = edf_pkg::exec_word(edf_pkg::TID_W'(idx_r));
  assign prod     = {{edf_pkg::FACTOR_W{1'b0}}, ex} * {{edf_pkg::EXEC_W{1'b0}}, factor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    item_take = 1'b0;
    scan      = 1'b0;
    res_wr    = 1'b0;
    unique case (state_r)
      edf_pkg::ST_IDLE: begin
        if (item_vld) begin
          item_take = 1'b1;
          state_nxt = edf_pkg::ST_SCAN;
        end
      end
      edf_pkg::ST_SCAN: begin
        scan = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = edf_pkg::ST_DRAIN;
        end
      end
      edf_pkg::ST_DRAIN: begin
        state_nxt = edf_pkg::ST_RESULT;
      end
      edf_pkg::ST_RESULT: begin
        if (!out_vld_r || out_rsp.ready) begin
          res_wr    = 1'b1;
          state_nxt = edf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = edf_pkg::ST_IDLE;
    endcase
  end

  assign do_pop = res_wr && (kind_r == edf_pkg::KIND_TICK) && q_head.vld;

  assign q_cmd.clr = item_take && (item.kind == edf_pkg::KIND_START);
  assign q_cmd.ins = p_vld_r && p_ins_r;
  assign q_cmd.pop = do_pop;
  assign q_cmd.tid = edf_pkg::TID_W'(p_idx_r);
  assign q_cmd.dl  = p_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      p_vld_r   <= 1'b0;
      p_ins_r   <= 1'b0;
      busy_r    <= '0;
      out_vld_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        period_r[i] <= '0;
        nrel_r[i]   <= '0;
      end
    end else begin
      p_vld_r <= scan;
      p_ins_r <= scan && (kind_r == edf_pkg::KIND_TICK) && rel && !busy_r[idx_r];
      if (item_take) begin
        idx_r <= '0;
        if (item.kind == edf_pkg::KIND_START) begin
          busy_r <= '0;
        end
      end else if (scan) begin
        if (idx_r != LAST_IDX) begin
          idx_r <= idx_r + IDX_W'(1);
        end
        if (kind_r == edf_pkg::KIND_TICK && rel) begin
          nrel_r[idx_r] <= sum;
          if (!busy_r[idx_r]) begin
            busy_r[idx_r] <= 1'b1;
          end
        end
      end
      // Second step of a start: store the period and the first release.
      if (p_vld_r && kind_r == edf_pkg::KIND_START) begin
        period_r[p_idx_r] <= p_val_r[edf_pkg::PERIOD_W-1:0];
        nrel_r[p_idx_r]   <= now_r + p_val_r;
      end
      if (do_pop) begin
        busy_r[q_head.tid[IDX_W-1:0]] <= 1'b0;
      end
      if (res_wr) begin
        out_vld_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      kind_r <= item.kind;
      now_r  <= item.now;
    end
    p_idx_r <= idx_r;
    p_val_r <= (kind_r == edf_pkg::KIND_TICK) ? sum : edf_pkg::TIME_W'(prod);
    if (res_wr) begin
      out_disp_r <= do_pop;
      out_tid_r  <= do_pop ? q_head.tid : '0;
    end
  end

  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.dispatched = out_disp_r;
  assign out_rsp.task_index = out_tid_r;

  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> busy_r[q_head.tid[IDX_W-1:0]])
    else $error("dispatched task was not marked busy");

  a_start_no_ins: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && kind_r == edf_pkg::KIND_START) |-> !q_cmd.ins)
    else $error("start item inserted into the ready queue");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_wr && kind_r == edf_pkg::KIND_START) |=> (!out_disp_r && out_tid_r == '0))
    else $error("start item produced a dispatch");

endmodule

// ----- design/edf_periodic_task_scheduler_core.sv -----
// Top level of the earliest-deadline-first periodic task scheduler.
//
// Channels: in_req carries request beats (req_type 0 = start, 1 = tick, with
// the current time now_us); out_rsp returns exactly one result beat for each
// request, in order, with dispatched and task_index; cfg_wr writes
// period_factor, which is always ready and only takes effect at the next start.
// A request beat is accepted when valid and ready are both high.
// The front end buffers up to two request beats. The back end handles one
// request at a time: it walks the task table one task per cycle through a
// two-step pipeline (compare and add, then sorted insertion or period store),
// drains that pipeline and writes the result register before it takes the
// next request. The walk over the task table bounds how fast requests are
// served; the ready queue inserts one task per cycle by comparing the new
// deadline in every slot at once.
// Reset empties the ready queue, clears every busy mark, period and release
// time, and sets period_factor to 20. When the receiver stalls, the result
// stays in the output register; the back end finishes the next request and
// then waits, and the front end keeps taking beats until its two entries fill.
module edf_periodic_task_scheduler_core #(
  parameter int NUM_TASKS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  edf_req_if.sink   in_req,
  edf_rsp_if.source out_rsp,
  edf_cfg_if.sink   cfg_wr
);

  logic [edf_pkg::FACTOR_W-1:0] factor_r;
  logic                         item_vld;
  edf_pkg::item_t               item;
  logic                         item_take;
  edf_pkg::qcmd_t               q_cmd;
  edf_pkg::qhead_t              q_head;

  // The configuration register can be written at any time.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= edf_pkg::FACTOR_RST;
    end else if (cfg_wr.valid) begin
      factor_r <= cfg_wr.period_factor;
    end
  end

  edf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take)
  );

  edf_back #(
    .NUM_TASKS (NUM_TASKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take),
    .factor    (factor_r),
    .q_cmd     (q_cmd),
    .q_head    (q_head),
    .out_rsp   (out_rsp)
  );

  edf_rdyq #(
    .NUM_TASKS (NUM_TASKS)
  ) u_rdyq (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .head  (q_head)
  );

endmodule

// ----- test/edf_periodic_task_scheduler_core_tb.sv -----
// Self-checking testbench of the EDF periodic task scheduler core.
module edf_periodic_task_scheduler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 2;
  localparam int NTASK          = 10;
  // Longer than a request holds the back end and than its result takes to
  // show up after acceptance, so this settles any work.
  localparam int SETTLE_CYCLES  = NTASK + 10;
  // Cycles in a row without any beat on any channel before the run is
  // declared hung. A correct run never gets close to this.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                      dispatched;
    logic [edf_pkg::TID_W-1:0] task_index;
  } dispatch_t;

  logic clk;
  logic rst_n;

  edf_req_if req_ch();
  edf_rsp_if rsp_ch();
  edf_cfg_if cfg_ch();

  edf_periodic_task_scheduler_core #(
    .NUM_TASKS(NTASK)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch),
    .cfg_wr (cfg_ch)
  );

  // Shadow copy of the scheduler: the factor register, each task's period,
  // next release time, absolute deadline and busy mark, and the ready queue
  // kept sorted by deadline.
  logic [edf_pkg::FACTOR_W-1:0] factor_q;
  logic [31:0]                  task_period [NTASK];
  logic [edf_pkg::TIME_W-1:0]   next_rel    [NTASK];
  logic [edf_pkg::TIME_W-1:0]   deadline    [NTASK];
  logic                         busy_mark   [NTASK];
  logic [edf_pkg::TID_W-1:0]    order_tid   [NTASK];
  logic                         order_vld   [NTASK];

  // Results owed by the block, oldest first.
  dispatch_t dispatches_due[$];

  int err_count;
  int n_starts;
  int n_ticks;
  int n_dispatched;
  int n_writes;
  int stall_cycles;
  int src_idle_pct;
  int rcv_idle_pct;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Execution-time word of each task in microseconds.
  function automatic logic [31:0] exec_us(input int idx);
    case (idx)
      0:       return 32'd15;
      5:       return 32'd220000;
      6:       return 32'd5000;
      7:       return 32'd40000;
      8:       return 32'd60000;
      default: return 32'd5;
    endcase
  endfunction

  // Place a task into the ready queue. A task goes in front of the first
  // entry with a strictly later deadline, so equal deadlines keep their
  // arrival order.
  function automatic void enqueue_by_deadline(input int t);
    int i;
    int j;
    int pos;
    pos = NTASK;
    for (i = 0; i < NTASK; i++) begin
      if (pos == NTASK && (!order_vld[i] || deadline[t] < deadline[order_tid[i]])) begin
        pos = i;
      end
    end
    if (pos < NTASK) begin
      for (j = NTASK - 1; j > pos; j--) begin
        order_tid[j] = order_tid[j-1];
        order_vld[j] = order_vld[j-1];
      end
      order_tid[pos] = edf_pkg::TID_W'(t);
      order_vld[pos] = 1'b1;
    end
  endfunction

  // Apply one request to the shadow state and return the result it causes.
  function automatic dispatch_t release_and_dispatch(
      input edf_pkg::kind_t kind, input logic [edf_pkg::TIME_W-1:0] now_val);
    dispatch_t res;
    int i;
    int head;
    res.dispatched = 1'b0;
    res.task_index = '0;
    if (kind == edf_pkg::KIND_START) begin
      // A start empties the queue and rebuilds every period from the factor
      // that is current now; release times count from this moment.
      for (i = 0; i < NTASK; i++) begin
        order_vld[i]   = 1'b0;
        order_tid[i]   = '0;
        busy_mark[i]   = 1'b0;
        task_period[i] = exec_us(i) * {24'd0, factor_q};
        next_rel[i]    = now_val + {32'd0, task_period[i]};
      end
    end else begin
      // All sums wrap modulo 2^64 and compare as unsigned. A task that is
      // still busy is not queued again, but its release still moves on.
      for (i = 0; i < NTASK; i++) begin
        if (next_rel[i] <= now_val) begin
          if (!busy_mark[i]) begin
            busy_mark[i] = 1'b1;
            deadline[i]  = next_rel[i] + {32'd0, task_period[i]};
            enqueue_by_deadline(i);
          end
          next_rel[i] = next_rel[i] + {32'd0, task_period[i]};
        end
      end
      if (order_vld[0]) begin
        head = int'(order_tid[0]);
        for (i = 0; i < NTASK - 1; i++) begin
          order_tid[i] = order_tid[i+1];
          order_vld[i] = order_vld[i+1];
        end
        order_tid[NTASK-1] = '0;
        order_vld[NTASK-1] = 1'b0;
        busy_mark[head]    = 1'b0;
        res.dispatched     = 1'b1;
        res.task_index     = edf_pkg::TID_W'(head);
      end
    end
    return res;
  endfunction

  // Send one request beat, after a random number of idle cycles. Valid stays
  // high after acceptance so that back-to-back beats never drop it; the next
  // call or a pause lowers it.
  task automatic send_req(input edf_pkg::kind_t kind,
                          input logic [edf_pkg::TIME_W-1:0] now_val);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.now_us   <= now_val;
    do @(posedge clk); while (!req_ch.ready);
    dispatches_due.push_back(release_and_dispatch(kind, now_val));
    if (kind == edf_pkg::KIND_START) begin
      n_starts++;
    end else begin
      n_ticks++;
    end
  endtask

  // Stop sending and wait until every owed result has come back, then let
  // the back end settle.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (dispatches_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the period factor while the block is idle.
  task automatic write_factor(input logic [edf_pkg::FACTOR_W-1:0] f);
    drain_results();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.period_factor <= f;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    factor_q = f;
    n_writes++;
  endtask

  // Right after reset every period is zero, so every task is released on
  // each tick with deadline zero and the queue drains in index order.
  task automatic test_tick_before_start();
    send_req(edf_pkg::KIND_TICK, 64'd0);
    send_req(edf_pkg::KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(edf_pkg::KIND_TICK, 64'd5);
  endtask

  // Reset factor of 20: short tasks release first, ties keep index order,
  // and a long jump releases the slow tasks while short ones are late.
  task automatic test_release_order();
    send_req(edf_pkg::KIND_START, 64'd1000);
    send_req(edf_pkg::KIND_TICK, 64'd1000);
    send_req(edf_pkg::KIND_TICK, 64'd1100);
    send_req(edf_pkg::KIND_TICK, 64'd1300);
    send_req(edf_pkg::KIND_TICK, 64'd1300);
    send_req(edf_pkg::KIND_TICK, 64'd101000);
  endtask

  // Largest factor, then a zero factor, which gives zero periods after start.
  task automatic test_factor_extremes();
    write_factor(8'd255);
    send_req(edf_pkg::KIND_START, 64'd0);
    send_req(edf_pkg::KIND_TICK, 64'd30_600_000);
    write_factor(8'd0);
    send_req(edf_pkg::KIND_START, 64'd77);
    send_req(edf_pkg::KIND_TICK, 64'd77);
    send_req(edf_pkg::KIND_TICK, 64'd76);
  endtask

  // Factor 1 and ticks closer together than one dispatch per release can
  // keep up with, so tasks come due again while still waiting.
  task automatic test_late_release();
    write_factor(8'd1);
    send_req(edf_pkg::KIND_START, 64'd0);
    send_req(edf_pkg::KIND_TICK, 64'd5);
    send_req(edf_pkg::KIND_TICK, 64'd10);
    send_req(edf_pkg::KIND_TICK, 64'd30);
  endtask

  // Start just below the top of the time range so that releases and
  // deadlines wrap past zero.
  task automatic test_time_wrap();
    send_req(edf_pkg::KIND_START, 64'hFFFF_FFFF_FFFF_FFF6);
    send_req(edf_pkg::KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFB);
    send_req(edf_pkg::KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_req(edf_pkg::KIND_TICK, 64'd3);
    send_req(edf_pkg::KIND_TICK, 64'd40);
  endtask

  // Random schedules: each one optionally changes the factor, starts at a
  // random base time and then ticks forward. Most steps are short, so the
  // ready queue fills up and tasks run late; a few jump far enough to
  // release the slow tasks, and a few are noise or step back in time.
  task automatic test_random_schedules(input int n_items);
    int sent;
    int n_seq;
    int k;
    logic [edf_pkg::TIME_W-1:0] t;
    logic [edf_pkg::TIME_W-1:0] short_span;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(5))
          0:       write_factor(8'd1);
          1:       write_factor(8'd255);
          2:       write_factor(8'd0);
          default: write_factor(edf_pkg::FACTOR_W'($urandom_range(255, 1)));
        endcase
      end
      case ($urandom_range(3))
        0:       t = {$urandom, $urandom};
        1:       t = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(2000);
        default: t = {32'd0, $urandom_range(100000)};
      endcase
      send_req(edf_pkg::KIND_START, t);
      sent++;
      short_span = 64'd15 * factor_q;
      n_seq = $urandom_range(40, 5);
      for (k = 0; k < n_seq; k++) begin
        case ($urandom_range(15))
          0: send_req(edf_pkg::KIND_TICK, {$urandom, $urandom});
          1: send_req(edf_pkg::KIND_TICK, t - $urandom_range(500));
          2: begin
            t = t + {32'd0, $urandom_range(130000)} * factor_q;
            send_req(edf_pkg::KIND_TICK, t);
          end
          default: begin
            t = t + ($urandom % (short_span + 64'd1));
            send_req(edf_pkg::KIND_TICK, t);
          end
        endcase
        sent++;
      end
    end
  endtask

  // Receiver side: ready is redrawn every cycle from the current idle rate.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Every result beat is matched against the oldest owed result.
  always @(posedge clk) begin
    dispatch_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (dispatches_due.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing owed: dispatched=%0b task_index=%0d",
                 $time, rsp_ch.dispatched, rsp_ch.task_index);
      end else begin
        want = dispatches_due.pop_front();
        if (rsp_ch.dispatched !== want.dispatched) begin
          err_count++;
          $display("%0t: dispatched mismatch: expected %0b, got %0b",
                   $time, want.dispatched, rsp_ch.dispatched);
        end
        if (rsp_ch.task_index !== want.task_index) begin
          err_count++;
          $display("%0t: task_index mismatch: expected %0d, got %0d",
                   $time, want.task_index, rsp_ch.task_index);
        end
        if (rsp_ch.dispatched === 1'b1) begin
          n_dispatched++;
        end
      end
    end
  end

  // Watchdog: any beat on any channel resets the count of silent cycles.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still owed",
               $time, stall_cycles, dispatches_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= edf_pkg::KIND_START;
    req_ch.now_us       <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.period_factor <= '0;
    n_starts     = 0;
    n_ticks      = 0;
    n_writes     = 0;
    src_idle_pct = 25;
    rcv_idle_pct = 82;

    // Shadow state matches what reset leaves in the block.
    factor_q = edf_pkg::FACTOR_RST;
    for (int i = 0; i < NTASK; i++) begin
      task_period[i] = '0;
      next_rel[i]    = '0;
      deadline[i]    = '0;
      busy_mark[i]   = 1'b0;
      order_tid[i]   = '0;
      order_vld[i]   = 1'b0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sender mostly busy, receiver mostly stalling.
    test_tick_before_start();
    test_release_order();
    test_factor_extremes();
    test_late_release();
    test_time_wrap();
    test_random_schedules(340);

    // Roles swapped: sparse requests, eager receiver.
    src_idle_pct = 82;
    rcv_idle_pct = 25;
    test_random_schedules(340);

    // Full speed on both sides.
    src_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_schedules(345);

    drain_results();

    $display("Covered %0d start and %0d tick beats, %0d dispatches, %0d factor writes,",
             n_starts, n_ticks, n_dispatched, n_writes);
    $display("including ticks before start, time wrap, late tasks and factors 0, 1, 255.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
